@@ sv/ilt_pkg.sv @@
// Package with shared types and constants of the identifier lookup-or-insert table.
`default_nettype none
package ilt_pkg;

  localparam int unsigned IdentW  = 32;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned StatusW = 2;

  localparam logic [IdentW-1:0] ClearCode = '1;
  localparam logic [IdentW-1:0] EmptyMark = '0;

  typedef enum logic [StatusW-1:0] {
    STAT_FOUND    = 2'd0,
    STAT_INSERTED = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_CLEARED  = 2'd3
  } status_e;

  // Decision that one cell reports while the probe sits in it.
  typedef struct packed {
    logic hit;
    logic ins;
  } cell_res_t;

endpackage
`default_nettype wire

@@ sv/ilt_if.sv @@
// Valid/ready channel interfaces for identifier requests and lookup results.
`default_nettype none
interface ilt_in_if;
  import ilt_pkg::*;
  logic              valid;
  logic              ready;
  logic [IdentW-1:0] ident;

  modport source (output valid, output ident, input ready);
  modport sink (input valid, input ident, output ready);
endinterface

interface ilt_out_if;
  import ilt_pkg::*;
  logic               valid;
  logic               ready;
  logic [SlotW-1:0]   slot;
  logic [StatusW-1:0] status;

  modport source (output valid, output slot, output status, input ready);
  modport sink (input valid, input slot, input status, output ready);
endinterface
`default_nettype wire

@@ sv/ilt_cell.sv @@
// One table cell: holds one identifier and forwards the search probe to its neighbor.
`default_nettype none
module ilt_cell import ilt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              probe_i,
  input  logic [IdentW-1:0] key_i,
  output logic              pass_o,
  output cell_res_t         res_o
);

  logic [IdentW-1:0] entry_q;
  logic              probe_q;
  logic              is_equal;
  logic              is_empty;

  assign is_equal = (entry_q == key_i);
  assign is_empty = (entry_q == EmptyMark);

  // Equality wins over emptiness, so a zero key reports the empty cell as found.
  assign res_o.hit = probe_q & is_equal;
  assign res_o.ins = probe_q & is_empty & ~is_equal;
  assign pass_o    = probe_q & ~is_equal & ~is_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= EmptyMark;
      probe_q <= 1'b0;
    end else begin
      probe_q <= probe_i;
      if (clear_i) begin
        entry_q <= EmptyMark;
      end else if (res_o.ins) begin
        entry_q <= key_i;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/id_lookup_or_insert_table_top.sv @@
// Top level of the identifier lookup-or-insert table: cell row, sequencer and result register.
//
//   channel  | direction | payload               | transfer when
//   ---------+-----------+-----------------------+----------------------
//   in_i     | sink      | ident[31:0]           | in_i.valid & in_i.ready
//   out_o    | source    | slot[3:0], status[1:0]| out_o.valid & out_o.ready
//
// A probe walks the cell row one cell per cycle, and the sequencer writes the
// slot and status of the deciding entry, of a full table or of a clear request
// into the result register. One request is in flight at a time; the next is
// taken once the previous result has moved into the output register.
// Reset empties every entry at once. A stalled output holds the sequencer in
// its done state until the output register is free.
`default_nettype none
module id_lookup_or_insert_table_top import ilt_pkg::*; #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ilt_in_if.sink     in_i,
  ilt_out_if.source  out_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_DONE   = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [IdentW-1:0]  key_q;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [SlotW-1:0]   res_slot_q, res_slot_d;
  status_e            res_status_q, res_status_d;
  logic               out_valid_q, out_valid_d;
  logic [SlotW-1:0]   out_slot_q;
  status_e            out_status_q;

  logic               in_xfer;
  logic               is_clear;
  logic               start;
  logic               clear;
  logic               out_load;
  logic               hit_any;
  logic               ins_any;
  logic               full;
  logic [ENTRIES:0]   probe;
  cell_res_t          cell_res [ENTRIES];

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid & in_i.ready;
  assign is_clear   = (in_i.ident == ClearCode);
  assign start      = in_xfer & ~is_clear;
  assign clear      = in_xfer & is_clear;

  assign probe[0] = start;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    ilt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (clear),
      .probe_i (probe[g]),
      .key_i   (key_q),
      .pass_o  (probe[g+1]),
      .res_o   (cell_res[g])
    );
  end

  // At most one cell holds the probe, so a plain OR gathers its decision.
  always_comb begin
    hit_any = 1'b0;
    ins_any = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_any = hit_any | cell_res[i].hit;
      ins_any = ins_any | cell_res[i].ins;
    end
  end

  assign full     = probe[ENTRIES];
  assign out_load = (state_q == ST_DONE) & (~out_valid_q | out_o.ready);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    res_slot_d   = res_slot_q;
    res_status_d = res_status_q;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (clear) begin
          res_slot_d   = '0;
          res_status_d = STAT_CLEARED;
          state_d      = ST_DONE;
        end else if (start) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit_any) begin
          res_slot_d   = SlotW'(idx_q);
          res_status_d = STAT_FOUND;
          state_d      = ST_DONE;
        end else if (ins_any) begin
          res_slot_d   = SlotW'(idx_q);
          res_status_d = STAT_INSERTED;
          state_d      = ST_DONE;
        end else if (full) begin
          res_slot_d   = '0;
          res_status_d = STAT_FULL;
          state_d      = ST_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_slot_q   <= res_slot_d;
    res_status_q <= res_status_d;
    if (in_xfer) begin
      key_q <= in_i.ident;
    end
    if (out_load) begin
      out_slot_q   <= res_slot_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.slot   = out_slot_q;
  assign out_o.status = out_status_q;

`ifndef SYNTHESIS
  // The probe never splits: at most one cell forwards it.
  a_single_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(probe[ENTRIES:1]))
    else $error("more than one cell forwards the probe");

  // A probe only moves while a search is under way.
  a_probe_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (probe[ENTRIES:1] != '0) |-> (state_q == ST_SEARCH))
    else $error("probe moving outside a search");

  // A clear or full result always carries slot zero.
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == STAT_CLEARED || out_status_q == STAT_FULL))
    |-> (out_slot_q == '0))
    else $error("nonzero slot on clear or full result");

  // A taken request always leaves the idle state on the next cycle.
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q != ST_IDLE))
    else $error("request transfer did not start work");
`endif

endmodule
`default_nettype wire
